// ----- design/sobol_pkg.sv -----
// Shared types and constants for the Sobol sequence generator.
// Used by the stream interfaces, the direction memory and the top level.
package sobol_pkg;

    // Direction table geometry
    localparam int DIR_DEPTH = 32;
    localparam int DIR_AW    = 5;
    localparam int IDX_W     = 6;

    // Configuration port
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    // Field widths
    localparam int NUM_BITS_W = 6;
    localparam int DEGREE_W   = 5;
    localparam int POLY_W     = 17;
    localparam int CMD_W      = 2;
    localparam int LOAD_IDX_W = 5;
    localparam int INIT_W     = 18;
    localparam int POINT_W    = 32;
    localparam int STATUS_W   = 3;

    // Register indexes
    localparam logic [1:0] REG_NUM_BITS    = 2'd0;
    localparam logic [1:0] REG_DEGREE      = 2'd1;
    localparam logic [1:0] REG_POLY_COEFFS = 2'd2;

    // Reset value of num_bits
    localparam logic [NUM_BITS_W-1:0] NUM_BITS_RESET = 6'd32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT    = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_POINT     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_LOADED    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_RESTARTED = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 3'd4;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_ISSUE,
        ST_ACC,
        ST_NEXT_RD
    } state_t;

    // Direction memory access request
    typedef struct packed {
        logic              wr_en;
        logic [DIR_AW-1:0] wr_addr;
        logic              rd_en;
        logic [DIR_AW-1:0] rd_addr;
    } dir_req_t;

    // One result item
    typedef struct packed {
        logic [POINT_W-1:0]  point;
        logic [POINT_W-1:0]  point_index;
        logic [STATUS_W-1:0] status;
    } res_t;

endpackage

// ----- design/sobol_stream_if.sv -----
// Valid/ready stream interfaces for command items and result items.
// Depends on sobol_pkg for field widths.
interface sobol_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [sobol_pkg::CMD_W-1:0]         cmd;
    logic [sobol_pkg::LOAD_IDX_W-1:0]    load_index;
    logic [sobol_pkg::INIT_W-1:0]        init_value;

    modport source (output valid, output cmd, output load_index, output init_value,
                    input ready);
    modport sink   (input valid, input cmd, input load_index, input init_value,
                    output ready);
endinterface

interface sobol_res_if;
    logic                              valid;
    logic                              ready;
    logic [sobol_pkg::POINT_W-1:0]     point;
    logic [sobol_pkg::POINT_W-1:0]     point_index;
    logic [sobol_pkg::STATUS_W-1:0]    status;

    modport source (output valid, output point, output point_index, output status,
                    input ready);
    modport sink   (input valid, input point, input point_index, input status,
                    output ready);
endinterface

// ----- design/sobol_dir_mem.sv -----
// Direction number memory: one write and one registered read per cycle.
// Per-entry valid bits make unwritten entries read as zero. Uses sobol_pkg.
module sobol_dir_mem #(
    parameter int DATA_W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sobol_pkg::dir_req_t req,
    input  logic [DATA_W-1:0]   wr_data,
    output logic [DATA_W-1:0]   rd_data
);

    logic [DATA_W-1:0]               mem [sobol_pkg::DIR_DEPTH];
    logic [sobol_pkg::DIR_DEPTH-1:0] valid_reg;
    logic [DATA_W-1:0]               rd_data_reg;
    logic                            rd_valid_reg;

    // Write the array
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // Track written entries and validity of the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- design/sobol_sequence_generator_unit.sv -----
// Sobol sequence generator, one dimension, Gray-code order.
// Depends on sobol_pkg, sobol_stream_if and sobol_dir_mem.
//
// A load item with a valid index stores one initial direction number; its
// result is registered into the result buffer. A next item first reads the
// direction number chosen by the lowest zero bit of the counter from the
// table memory, then folds it into the point; an exhausted request answers
// without a table read. A restart item with s below L rebuilds the table
// through the single memory read port: for degree 0 it writes all 32
// entries, one a cycle; otherwise each entry from s+1 to L is built with
// one read and one accumulate per tap. A two-entry result buffer lets a
// new item enter while one result waits.
// The table resets to zero through per-entry valid bits, with no clearing pass.
// Registers via APB: num_bits at 0x0, degree at 0x4, poly_coeffs at 0x8.
module sobol_sequence_generator_unit #(
    parameter int FRACTION_BITS = 32,
    parameter int MAX_DEGREE    = 18
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sobol_pkg::CFG_AW-1:0]  paddr,
    input  logic [sobol_pkg::CFG_DW-1:0]  pwdata,
    output logic [sobol_pkg::CFG_DW-1:0]  prdata,
    output logic                          pready,
    sobol_cmd_if.sink                     cmd_ch,
    sobol_res_if.source                   res_ch
);

    localparam int FB = FRACTION_BITS;
    localparam logic [sobol_pkg::DEGREE_W-1:0] MAX_DEG_V = sobol_pkg::DEGREE_W'(MAX_DEGREE);
    localparam logic [sobol_pkg::IDX_W-1:0]    DEPTH_V   = sobol_pkg::IDX_W'(sobol_pkg::DIR_DEPTH);

    // Configuration registers
    logic [sobol_pkg::NUM_BITS_W-1:0] num_bits_reg;
    logic [sobol_pkg::DEGREE_W-1:0]   degree_reg;
    logic [sobol_pkg::POLY_W-1:0]     poly_reg;

    // Sequencer and datapath state
    sobol_pkg::state_t                state_reg, state_next;
    logic [FB-1:0]                    pt_reg, pt_next;
    logic [sobol_pkg::POINT_W-1:0]    cnt_reg, cnt_next;
    logic [sobol_pkg::IDX_W-1:0]      i_reg, i_next;
    logic [sobol_pkg::DEGREE_W-1:0]   tap_reg, tap_next;
    logic [FB-1:0]                    acc_reg, acc_next;

    // Result buffer
    sobol_pkg::res_t                  out_reg, hold_reg, res_val;
    logic                             out_valid_reg, hold_valid_reg;
    logic                             res_new;

    // Memory access
    sobol_pkg::dir_req_t              req;
    logic [FB-1:0]                    wr_data;
    logic [FB-1:0]                    rd_data;

    // Derived values
    logic                             accept;
    logic [sobol_pkg::IDX_W-1:0]      l_eff;
    logic [sobol_pkg::DEGREE_W-1:0]   s_eff;
    logic [sobol_pkg::POINT_W:0]      limit;
    logic                             exhausted;
    logic [sobol_pkg::DIR_AW-1:0]     low_zero;
    logic                             bad_index;
    logic [FB+sobol_pkg::INIT_W-1:0]  load_wide;
    logic [FB:0]                      fill_wide;
    logic [31:0]                      coeff_ext;
    logic [sobol_pkg::DEGREE_W-1:0]   coeff_idx;
    logic                             coeff_bit;
    logic                             last_tap;
    logic [FB-1:0]                    acc_val;
    logic [sobol_pkg::IDX_W-1:0]      s_ext;
    logic [sobol_pkg::IDX_W-1:0]      tap_ext;
    logic                             cfg_wr;

    sobol_dir_mem #(
        .DATA_W (FB)
    ) u_dir_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // Align an internal fraction to a 0.32 point
    function automatic logic [sobol_pkg::POINT_W-1:0] to_point32(input logic [FB-1:0] x);
        logic [FB+sobol_pkg::POINT_W-1:0] ext;
        ext = {x, {sobol_pkg::POINT_W{1'b0}}};
        return ext[FB+sobol_pkg::POINT_W-1:FB];
    endfunction

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bits_reg <= sobol_pkg::NUM_BITS_RESET;
            degree_reg   <= '0;
            poly_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                sobol_pkg::REG_NUM_BITS:    num_bits_reg <= pwdata[sobol_pkg::NUM_BITS_W-1:0];
                sobol_pkg::REG_DEGREE:      degree_reg   <= pwdata[sobol_pkg::DEGREE_W-1:0];
                sobol_pkg::REG_POLY_COEFFS: poly_reg     <= pwdata[sobol_pkg::POLY_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            sobol_pkg::REG_NUM_BITS:    prdata = {26'd0, num_bits_reg};
            sobol_pkg::REG_DEGREE:      prdata = {27'd0, degree_reg};
            sobol_pkg::REG_POLY_COEFFS: prdata = {15'd0, poly_reg};
            default:                    prdata = '0;
        endcase
    end

    // Clamp the configuration
    always_comb
    begin
        if (num_bits_reg == '0)
        begin
            l_eff = sobol_pkg::IDX_W'(1);
        end
        else if (num_bits_reg > DEPTH_V)
        begin
            l_eff = DEPTH_V;
        end
        else
        begin
            l_eff = num_bits_reg;
        end
        s_eff = (degree_reg > MAX_DEG_V) ? MAX_DEG_V : degree_reg;
    end

    assign s_ext   = {1'b0, s_eff};
    assign tap_ext = {1'b0, tap_reg};

    // Exhaustion test and lowest zero bit of the counter
    assign limit     = ((sobol_pkg::POINT_W+1)'(1) << l_eff) - (sobol_pkg::POINT_W+1)'(1);
    assign exhausted = {1'b0, cnt_reg} >= limit;

    always_comb
    begin
        low_zero = sobol_pkg::DIR_AW'(sobol_pkg::DIR_DEPTH - 1);
        for (int b = sobol_pkg::DIR_DEPTH - 2; b >= 0; b--)
        begin
            if (!cnt_reg[b])
            begin
                low_zero = sobol_pkg::DIR_AW'(b);
            end
        end
    end

    // Scaled direction numbers for load and first-dimension fill
    assign bad_index = (cmd_ch.load_index == '0) ||
                       ({1'b0, cmd_ch.load_index} > {1'b0, MAX_DEG_V});
    assign load_wide = {cmd_ch.init_value, {FB{1'b0}}} >> cmd_ch.load_index;
    assign fill_wide = {1'b1, {FB{1'b0}}} >> i_reg;

    // Recurrence tap
    assign coeff_ext = {15'd0, poly_reg};
    assign coeff_idx = s_eff - sobol_pkg::DEGREE_W'(1) - tap_reg;
    assign coeff_bit = coeff_ext[coeff_idx];
    assign last_tap  = (tap_reg == s_eff - sobol_pkg::DEGREE_W'(1));

    always_comb
    begin
        if (tap_reg == '0)
        begin
            acc_val = rd_data ^ (rd_data >> s_eff);
        end
        else if (coeff_bit)
        begin
            acc_val = acc_reg ^ rd_data;
        end
        else
        begin
            acc_val = acc_reg;
        end
    end

    assign accept       = cmd_ch.valid && cmd_ch.ready;
    assign cmd_ch.ready = (state_reg == sobol_pkg::ST_IDLE) && !hold_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sobol_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_ch.cmd == sobol_pkg::CMD_RESTART)
                    begin
                        if (s_eff == '0)
                        begin
                            state_next = sobol_pkg::ST_FILL;
                        end
                        else if (s_ext < l_eff)
                        begin
                            state_next = sobol_pkg::ST_ISSUE;
                        end
                    end
                    else if (cmd_ch.cmd == sobol_pkg::CMD_NEXT && !exhausted)
                    begin
                        state_next = sobol_pkg::ST_NEXT_RD;
                    end
                end
            end
            sobol_pkg::ST_FILL:
            begin
                if (i_reg == DEPTH_V)
                begin
                    state_next = sobol_pkg::ST_IDLE;
                end
            end
            sobol_pkg::ST_ISSUE:
            begin
                state_next = sobol_pkg::ST_ACC;
            end
            sobol_pkg::ST_ACC:
            begin
                if (last_tap && i_reg == l_eff)
                begin
                    state_next = sobol_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = sobol_pkg::ST_ISSUE;
                end
            end
            sobol_pkg::ST_NEXT_RD:
            begin
                state_next = sobol_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sobol_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        req      = '0;
        wr_data  = '0;
        res_new  = 1'b0;
        res_val  = '0;
        pt_next  = pt_reg;
        cnt_next = cnt_reg;
        i_next   = i_reg;
        tap_next = tap_reg;
        acc_next = acc_reg;
        unique case (state_reg)
            sobol_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_ch.cmd)
                        sobol_pkg::CMD_LOAD:
                        begin
                            res_new = 1'b1;
                            if (bad_index)
                            begin
                                res_val.status = sobol_pkg::STATUS_BAD_INDEX;
                            end
                            else
                            begin
                                req.wr_en      = 1'b1;
                                req.wr_addr    = sobol_pkg::DIR_AW'(cmd_ch.load_index - 1'b1);
                                wr_data        = load_wide[FB-1:0];
                                res_val.status = sobol_pkg::STATUS_LOADED;
                            end
                        end
                        sobol_pkg::CMD_RESTART:
                        begin
                            pt_next  = '0;
                            cnt_next = '0;
                            tap_next = '0;
                            if (s_eff == '0)
                            begin
                                i_next = sobol_pkg::IDX_W'(1);
                            end
                            else if (s_ext < l_eff)
                            begin
                                i_next = s_ext + sobol_pkg::IDX_W'(1);
                            end
                            else
                            begin
                                res_new        = 1'b1;
                                res_val.status = sobol_pkg::STATUS_RESTARTED;
                            end
                        end
                        sobol_pkg::CMD_NEXT:
                        begin
                            if (exhausted)
                            begin
                                res_new             = 1'b1;
                                res_val.point       = to_point32(pt_reg);
                                res_val.point_index = cnt_reg;
                                res_val.status      = sobol_pkg::STATUS_EXHAUSTED;
                            end
                            else
                            begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = low_zero;
                            end
                        end
                        default:
                        begin
                            // Unused command: drop without a result
                        end
                    endcase
                end
            end
            sobol_pkg::ST_FILL:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = sobol_pkg::DIR_AW'(i_reg - sobol_pkg::IDX_W'(1));
                wr_data     = fill_wide[FB-1:0];
                i_next      = i_reg + sobol_pkg::IDX_W'(1);
                if (i_reg == DEPTH_V)
                begin
                    res_new        = 1'b1;
                    res_val.status = sobol_pkg::STATUS_RESTARTED;
                end
            end
            sobol_pkg::ST_ISSUE:
            begin
                // Base term first, then the inner taps
                req.rd_en = 1'b1;
                if (tap_reg == '0)
                begin
                    req.rd_addr = sobol_pkg::DIR_AW'(i_reg - s_ext - sobol_pkg::IDX_W'(1));
                end
                else
                begin
                    req.rd_addr = sobol_pkg::DIR_AW'(i_reg - tap_ext - sobol_pkg::IDX_W'(1));
                end
            end
            sobol_pkg::ST_ACC:
            begin
                acc_next = acc_val;
                if (last_tap)
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = sobol_pkg::DIR_AW'(i_reg - sobol_pkg::IDX_W'(1));
                    wr_data     = acc_val;
                    tap_next    = '0;
                    i_next      = i_reg + sobol_pkg::IDX_W'(1);
                    if (i_reg == l_eff)
                    begin
                        res_new        = 1'b1;
                        res_val.status = sobol_pkg::STATUS_RESTARTED;
                    end
                end
                else
                begin
                    tap_next = tap_reg + sobol_pkg::DEGREE_W'(1);
                end
            end
            sobol_pkg::ST_NEXT_RD:
            begin
                pt_next             = pt_reg ^ rd_data;
                cnt_next            = cnt_reg + sobol_pkg::POINT_W'(1);
                res_new             = 1'b1;
                res_val.point       = to_point32(pt_next);
                res_val.point_index = cnt_next;
                res_val.status      = sobol_pkg::STATUS_POINT;
            end
            default:
            begin
            end
        endcase
    end

    // Control and point state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sobol_pkg::ST_IDLE;
            pt_reg    <= '0;
            cnt_reg   <= '0;
            i_reg     <= '0;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pt_reg    <= pt_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            tap_reg   <= tap_next;
        end
    end

    // Recurrence accumulator
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Result buffer: output slot plus one holding slot
    logic out_free;
    assign out_free = !out_valid_reg || res_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= hold_valid_reg || res_new;
            hold_valid_reg <= hold_valid_reg && res_new;
        end
        else if (res_new)
        begin
            hold_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (hold_valid_reg)
            begin
                out_reg <= hold_reg;
                if (res_new)
                begin
                    hold_reg <= res_val;
                end
            end
            else if (res_new)
            begin
                out_reg <= res_val;
            end
        end
        else if (res_new)
        begin
            hold_reg <= res_val;
        end
    end

    assign res_ch.valid       = out_valid_reg;
    assign res_ch.point       = out_reg.point;
    assign res_ch.point_index = out_reg.point_index;
    assign res_ch.status      = out_reg.status;

endmodule
